// File: hw/rtl/ode_system_step_solver_core_assert.svh
// Assertion macros for the checker file of the step solver.
`ifndef ODE_SYSTEM_STEP_SOLVER_CORE_ASSERT_SVH
`define ODE_SYSTEM_STEP_SOLVER_CORE_ASSERT_SVH

// Antecedent holds in one cycle, consequent in the next.
`define ODESS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Antecedent and consequent in the same cycle.
`define ODESS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/odess_pkg.sv
// ----------------------------------------------------------------------------
// odess_pkg
// Types, codes and the micro-program table of the ODE step solver.
// ----------------------------------------------------------------------------
package odess_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int VAL_W         = 32;
  localparam int STEP_W        = 17;
  localparam int H6_W          = 15;
  localparam int SUM_W         = 35;
  localparam int CFG_AW        = 1;
  localparam int CFG_DW        = 17;
  localparam int IDX_W         = 4;

  localparam logic [STEP_W-1:0] STEP_RST = 17'd13107;

  localparam logic [CFG_AW-1:0] REG_STEP_SIZE = 1'b0;
  localparam logic [CFG_AW-1:0] REG_METHOD    = 1'b1;

  localparam logic OP_STEP = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  typedef enum logic [1:0] {
    METH_EULER = 2'd0,
    METH_MID   = 2'd1,
    METH_HEUN  = 2'd2,
    METH_RK4   = 2'd3
  } method_e;

  typedef enum logic [2:0] {
    MOP_DERIV,
    MOP_PA,
    MOP_PB,
    MOP_FA,
    MOP_FB
  } mop_e;

  typedef enum logic [1:0] {
    XS_CUR,
    XS_HALF,
    XS_FULL
  } xsel_e;

  typedef enum logic [1:0] {
    CS_H,
    CS_HH,
    CS_H6
  } csel_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WB,
    ST_DONE
  } state_e;

  typedef struct packed {
    mop_e        mop;
    xsel_e       xsel;
    csel_e       csel;
    logic [1:0]  weight;
    logic        last;
  } uop_t;

  typedef struct packed {
    logic start;
    logic load;
    logic issue;
    logic wb;
    logic out_write;
    uop_t uop;
  } cmd_t;

  typedef struct packed {
    method_e method;
  } status_t;

  typedef struct packed {
    logic                    operation;
    logic signed [VAL_W-1:0] abscissa;
    logic signed [VAL_W-1:0] load_first;
    logic signed [VAL_W-1:0] load_second;
  } in_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] first_out;
    logic signed [VAL_W-1:0] second_out;
    logic                    saturated;
  } out_item_t;

  function automatic uop_t mk(mop_e m, xsel_e x, csel_e c, logic [1:0] w, logic l);
    uop_t u;
    u.mop = m; u.xsel = x; u.csel = c; u.weight = w; u.last = l;
    return u;
  endfunction

  // Micro-program: one entry per multiply of the selected method.
  function automatic uop_t uop_lookup(method_e meth, logic [IDX_W-1:0] idx);
    uop_t u;
    u = mk(MOP_FB, XS_CUR, CS_H, 2'd0, 1'b1);
    case (meth)
      METH_EULER: begin
        case (idx)
          4'd0:    u = mk(MOP_DERIV, XS_CUR, CS_H, 2'd1, 1'b0);
          4'd1:    u = mk(MOP_FA, XS_CUR, CS_H, 2'd0, 1'b0);
          default: u = mk(MOP_FB, XS_CUR, CS_H, 2'd0, 1'b1);
        endcase
      end
      METH_MID: begin
        case (idx)
          4'd0:    u = mk(MOP_DERIV, XS_CUR, CS_HH, 2'd0, 1'b0);
          4'd1:    u = mk(MOP_PA, XS_CUR, CS_HH, 2'd0, 1'b0);
          4'd2:    u = mk(MOP_PB, XS_CUR, CS_HH, 2'd0, 1'b0);
          4'd3:    u = mk(MOP_DERIV, XS_HALF, CS_H, 2'd1, 1'b0);
          4'd4:    u = mk(MOP_FA, XS_CUR, CS_H, 2'd0, 1'b0);
          default: u = mk(MOP_FB, XS_CUR, CS_H, 2'd0, 1'b1);
        endcase
      end
      METH_HEUN: begin
        case (idx)
          4'd0:    u = mk(MOP_DERIV, XS_CUR, CS_H, 2'd1, 1'b0);
          4'd1:    u = mk(MOP_PA, XS_CUR, CS_H, 2'd0, 1'b0);
          4'd2:    u = mk(MOP_PB, XS_CUR, CS_H, 2'd0, 1'b0);
          4'd3:    u = mk(MOP_DERIV, XS_FULL, CS_HH, 2'd1, 1'b0);
          4'd4:    u = mk(MOP_FA, XS_CUR, CS_HH, 2'd0, 1'b0);
          default: u = mk(MOP_FB, XS_CUR, CS_HH, 2'd0, 1'b1);
        endcase
      end
      default: begin
        case (idx)
          4'd0:    u = mk(MOP_DERIV, XS_CUR, CS_HH, 2'd1, 1'b0);
          4'd1:    u = mk(MOP_PA, XS_CUR, CS_HH, 2'd0, 1'b0);
          4'd2:    u = mk(MOP_PB, XS_CUR, CS_HH, 2'd0, 1'b0);
          4'd3:    u = mk(MOP_DERIV, XS_HALF, CS_HH, 2'd2, 1'b0);
          4'd4:    u = mk(MOP_PA, XS_CUR, CS_HH, 2'd0, 1'b0);
          4'd5:    u = mk(MOP_PB, XS_CUR, CS_HH, 2'd0, 1'b0);
          4'd6:    u = mk(MOP_DERIV, XS_HALF, CS_H, 2'd2, 1'b0);
          4'd7:    u = mk(MOP_PA, XS_CUR, CS_H, 2'd0, 1'b0);
          4'd8:    u = mk(MOP_PB, XS_CUR, CS_H, 2'd0, 1'b0);
          4'd9:    u = mk(MOP_DERIV, XS_FULL, CS_H6, 2'd1, 1'b0);
          4'd10:   u = mk(MOP_FA, XS_CUR, CS_H6, 2'd0, 1'b0);
          default: u = mk(MOP_FB, XS_CUR, CS_H6, 2'd0, 1'b1);
        endcase
      end
    endcase
    return u;
  endfunction

endpackage

// File: hw/rtl/ode_system_step_solver_core.sv
// ----------------------------------------------------------------------------
// ode_system_step_solver_core
// Fixed-point step solver for y1' = y2, y2' = x*y2 - y1 (Euler, RK2, RK4).
// ----------------------------------------------------------------------------
// Channel  | Signals                          | Transfer when
// in       | in_valid_i/in_ready_o, in_item_i | in_valid_i & in_ready_o
// out      | out_valid_o/out_ready_i, out_item_o | out_valid_o & out_ready_i
// cfg      | cfg_we_i, cfg_addr_i, cfg_wdata_i | cfg_we_i
//
// A load passes through the DONE state, where it is written to the result
// register once that register is free. A step passes through an ISSUE and a WB
// state for each of its M multiplies before DONE, M being the multiply count
// of the method (Euler 3, midpoint and Heun 6, RK4 12): on the single shared
// multiplier, ISSUE forms the product and WB rounds, clamps and adds. The next
// input transfer can follow once the item has left the DONE state.
// One item is in flight; the output register holds a finished result while a
// stalled consumer lets the next item start.
// Reset restores step 0.2, RK4 and the pair (2.0, 1.0).
// ----------------------------------------------------------------------------
module ode_system_step_solver_core #(
  parameter int FRAC_BITS = odess_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [odess_pkg::CFG_AW-1:0]  cfg_addr_i,
  input  logic [odess_pkg::CFG_DW-1:0]  cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  odess_pkg::in_item_t           in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output odess_pkg::out_item_t          out_item_o
);

  odess_pkg::cmd_t    cmd;
  odess_pkg::status_t status;

  // Sequencer: issues one micro-op pair per multiply.
  odess_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_op_i     (in_item_i.operation),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Datapath: state pair, stage registers and the shared multiplier.
  odess_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_item_o  (out_item_o)
  );

endmodule

// File: hw/rtl/odess_datapath.sv
// ----------------------------------------------------------------------------
// odess_datapath
// Configuration, state pair, shared multiplier and round/clamp/add unit.
// ----------------------------------------------------------------------------
module odess_datapath #(
  parameter int FRAC_BITS = odess_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [odess_pkg::CFG_AW-1:0]  cfg_addr_i,
  input  logic [odess_pkg::CFG_DW-1:0]  cfg_wdata_i,
  input  odess_pkg::in_item_t           in_item_i,
  input  odess_pkg::cmd_t               cmd_i,
  output odess_pkg::status_t            status_o,
  output odess_pkg::out_item_t          out_item_o
);

  localparam int VW = odess_pkg::VAL_W;
  localparam int SW = odess_pkg::SUM_W;
  localparam int BW = VW + 1;
  localparam int PW = SW + BW;

  localparam logic [63:0] TWO_Q = 64'd2 << FRAC_BITS;
  localparam logic signed [VW-1:0] FIRST_RST =
    (TWO_Q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : TWO_Q[VW-1:0];
  localparam logic signed [VW-1:0] SECOND_RST = VW'(64'd1 << FRAC_BITS);
  localparam logic signed [PW-1:0] RND  = PW'(64'd1 << (FRAC_BITS - 1));
  localparam logic signed [PW-1:0] PMAX = PW'(64'h7FFF_FFFF);
  localparam logic signed [PW-1:0] PMIN = -PW'(64'h8000_0000);
  localparam logic signed [BW-1:0] AMAX = BW'(64'h7FFF_FFFF);
  localparam logic signed [BW-1:0] AMIN = -BW'(64'h8000_0000);

  logic [odess_pkg::STEP_W-1:0] h_q;
  logic [odess_pkg::H6_W-1:0]   h6_q;
  odess_pkg::method_e           meth_q;
  logic [odess_pkg::STEP_W+17:0] h6_prod;

  logic signed [VW-1:0] y1_q, y2_q, x_q, xh2_q, xh_q, p1_q, p2_q, ka_q, kb_q;
  logic signed [SW-1:0] s1_q, s2_q;
  logic signed [PW-1:0] prod_q;
  logic                 flag_q;
  odess_pkg::out_item_t out_q;

  logic signed [BW-1:0] xh2_sum, xh_sum;
  logic signed [VW-1:0] xh2_sat, xh_sat;
  logic                 xh2_ovf, xh_ovf;

  logic signed [SW-1:0] mul_a;
  logic signed [BW-1:0] mul_b, coef;
  logic signed [PW-1:0] rsh;
  logic signed [VW-1:0] rval, sval, base;
  logic signed [BW-1:0] asum;
  logic                 r_ovf, s_ovf;
  logic signed [SW-1:0] wa, wb;

  // h/6 by reciprocal: floor(h * 174763 / 2^20) is exact over 17 bits.
  assign h6_prod = h_q * 18'd174763;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_q    <= odess_pkg::STEP_RST;
      meth_q <= odess_pkg::METH_RK4;
      h6_q   <= '0;
    end else begin
      h6_q <= h6_prod[20 +: odess_pkg::H6_W];
      if (cfg_we_i) begin
        case (cfg_addr_i)
          odess_pkg::REG_STEP_SIZE: h_q    <= cfg_wdata_i;
          odess_pkg::REG_METHOD:    meth_q <= odess_pkg::method_e'(cfg_wdata_i[1:0]);
          default: ;
        endcase
      end
    end
  end

  assign status_o.method = meth_q;

  // Shifted abscissas, clamped at step start.
  always_comb begin
    xh2_sum = BW'(in_item_i.abscissa) + $signed(BW'(h_q >> 1));
    xh_sum  = BW'(in_item_i.abscissa) + $signed(BW'(h_q));
    xh2_ovf = (xh2_sum > AMAX) || (xh2_sum < AMIN);
    xh_ovf  = (xh_sum > AMAX) || (xh_sum < AMIN);
    xh2_sat = (xh2_sum > AMAX) ? AMAX[VW-1:0] :
              (xh2_sum < AMIN) ? AMIN[VW-1:0] : xh2_sum[VW-1:0];
    xh_sat  = (xh_sum > AMAX) ? AMAX[VW-1:0] :
              (xh_sum < AMIN) ? AMIN[VW-1:0] : xh_sum[VW-1:0];
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    case (cmd_i.uop.csel)
      odess_pkg::CS_HH: coef = $signed(BW'(h_q >> 1));
      odess_pkg::CS_H6: coef = $signed(BW'(h6_q));
      default:          coef = $signed(BW'(h_q));
    endcase
    mul_b = coef;
    case (cmd_i.uop.mop)
      odess_pkg::MOP_DERIV: begin
        mul_b = BW'(p2_q);
        case (cmd_i.uop.xsel)
          odess_pkg::XS_HALF: mul_a = SW'(xh2_q);
          odess_pkg::XS_FULL: mul_a = SW'(xh_q);
          default:            mul_a = SW'(x_q);
        endcase
      end
      odess_pkg::MOP_PA: mul_a = SW'(ka_q);
      odess_pkg::MOP_PB: mul_a = SW'(kb_q);
      odess_pkg::MOP_FA: mul_a = s1_q;
      default:           mul_a = s2_q;
    endcase
  end

  // Round to nearest, clamp, then clamped add or subtract.
  always_comb begin
    rsh   = (prod_q + RND) >>> FRAC_BITS;
    r_ovf = (rsh > PMAX) || (rsh < PMIN);
    rval  = (rsh > PMAX) ? PMAX[VW-1:0] : (rsh < PMIN) ? PMIN[VW-1:0] : rsh[VW-1:0];
    case (cmd_i.uop.mop)
      odess_pkg::MOP_PA, odess_pkg::MOP_FA: base = y1_q;
      odess_pkg::MOP_PB, odess_pkg::MOP_FB: base = y2_q;
      default:                              base = p1_q;
    endcase
    if (cmd_i.uop.mop == odess_pkg::MOP_DERIV) asum = BW'(rval) - BW'(base);
    else                                       asum = BW'(rval) + BW'(base);
    s_ovf = (asum > AMAX) || (asum < AMIN);
    sval  = (asum > AMAX) ? AMAX[VW-1:0] : (asum < AMIN) ? AMIN[VW-1:0] : asum[VW-1:0];
    case (cmd_i.uop.weight)
      2'd1:    begin wa = SW'(p2_q);         wb = SW'(sval);         end
      2'd2:    begin wa = SW'(p2_q) <<< 1;   wb = SW'(sval) <<< 1;   end
      default: begin wa = '0;                wb = '0;                end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      y1_q <= FIRST_RST;
      y2_q <= SECOND_RST;
    end else if (cmd_i.load) begin
      y1_q <= in_item_i.load_first;
      y2_q <= in_item_i.load_second;
    end else if (cmd_i.wb && cmd_i.uop.mop == odess_pkg::MOP_FA) begin
      y1_q <= sval;
    end else if (cmd_i.wb && cmd_i.uop.mop == odess_pkg::MOP_FB) begin
      y2_q <= sval;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) prod_q <= mul_a * mul_b;
    if (cmd_i.load) flag_q <= 1'b0;
    if (cmd_i.start) begin
      x_q    <= in_item_i.abscissa;
      xh2_q  <= xh2_sat;
      xh_q   <= xh_sat;
      p1_q   <= y1_q;
      p2_q   <= y2_q;
      s1_q   <= '0;
      s2_q   <= '0;
      flag_q <= xh2_ovf | xh_ovf;
    end
    if (cmd_i.wb) begin
      flag_q <= flag_q | r_ovf | s_ovf;
      case (cmd_i.uop.mop)
        odess_pkg::MOP_DERIV: begin
          ka_q <= p2_q;
          kb_q <= sval;
          s1_q <= s1_q + wa;
          s2_q <= s2_q + wb;
        end
        odess_pkg::MOP_PA: p1_q <= sval;
        odess_pkg::MOP_PB: p2_q <= sval;
        default: ;
      endcase
    end
    if (cmd_i.out_write) begin
      out_q.first_out  <= y1_q;
      out_q.second_out <= y2_q;
      out_q.saturated  <= flag_q;
    end
  end

  assign out_item_o = out_q;

endmodule

// File: hw/rtl/odess_ctrl.sv
// ----------------------------------------------------------------------------
// odess_ctrl
// Sequencer: walks the micro-program and runs the input/output handshakes.
// ----------------------------------------------------------------------------
module odess_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_op_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  odess_pkg::status_t  status_i,
  output odess_pkg::cmd_t     cmd_o
);

  odess_pkg::state_e state_q, state_d;
  logic [odess_pkg::IDX_W-1:0] idx_q, idx_d;
  logic out_valid_q, out_valid_d;
  logic in_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= odess_pkg::ST_IDLE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    idx_d         = idx_q;
    cmd_o         = '0;
    cmd_o.uop     = odess_pkg::uop_lookup(status_i.method, idx_q);
    in_ready_o    = (state_q == odess_pkg::ST_IDLE);
    in_fire       = in_valid_i && in_ready_o;
    out_valid_d   = out_valid_q && !out_ready_i;
    case (state_q)
      odess_pkg::ST_IDLE: begin
        if (in_fire) begin
          idx_d = '0;
          if (in_op_i == odess_pkg::OP_LOAD) begin
            cmd_o.load = 1'b1;
            state_d    = odess_pkg::ST_DONE;
          end else begin
            cmd_o.start = 1'b1;
            state_d     = odess_pkg::ST_ISSUE;
          end
        end
      end
      odess_pkg::ST_ISSUE: begin
        cmd_o.issue = 1'b1;
        state_d     = odess_pkg::ST_WB;
      end
      odess_pkg::ST_WB: begin
        cmd_o.wb = 1'b1;
        if (cmd_o.uop.last) begin
          state_d = odess_pkg::ST_DONE;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = odess_pkg::ST_ISSUE;
        end
      end
      odess_pkg::ST_DONE: begin
        // Hold the result until the output register is free.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_write = 1'b1;
          out_valid_d     = 1'b1;
          state_d         = odess_pkg::ST_IDLE;
        end
      end
      default: state_d = odess_pkg::ST_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: hw/rtl/odess_checker.sv
// ----------------------------------------------------------------------------
// odess_checker
// Port-level checks of the step solver, bound to the top level.
// ----------------------------------------------------------------------------
`include "ode_system_step_solver_core_assert.svh"

module odess_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_i,
  input logic                 out_valid_i,
  input logic                 out_ready_i,
  input odess_pkg::out_item_t out_item_i
);

  `ODESS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i, "result dropped while stalled")
  `ODESS_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_i && !out_ready_i, $stable(out_item_i), "result changed while stalled")
  `ODESS_ASSERT_NEXT(a_one_in_flight, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i, "second item taken while busy")

endmodule

bind ode_system_step_solver_core odess_checker u_odess_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_i  (in_ready_o),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_i  (out_item_o)
);

// File: verif/ode_step_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ode_step_checker
// Watches the item and result channels of the ODE step solver, integrates
// the system alongside it in fixed point and compares every result.
// ----------------------------------------------------------------------------
module ode_step_checker
  import odess_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic [CFG_AW-1:0] cfg_addr_i,
  input  logic [CFG_DW-1:0] cfg_wdata_i,
  input  logic      in_valid_i,
  input  logic      in_ready_i,
  input  in_item_t  in_item_i,
  input  logic      out_valid_i,
  input  logic      out_ready_i,
  input  out_item_t out_item_i,
  output int        fail_count_o,
  output int        pending_o
);

  localparam longint QMAX = 64'sd2147483647;
  localparam longint QMIN = -64'sd2147483648;

  logic [STEP_W-1:0] h_reg;
  method_e           meth_reg;
  longint            y1_st, y2_st;
  bit                clamped;
  out_item_t         expected_q[$];

  function automatic longint clamp32(longint v);
    if (v > QMAX) begin clamped = 1; return QMAX; end
    if (v < QMIN) begin clamped = 1; return QMIN; end
    return v;
  endfunction

  function automatic longint qmul(longint a, longint b);
    longint p;
    p = a * b + (64'sd1 << (FRAC_BITS_DEF - 1));
    return clamp32(p >>> FRAC_BITS_DEF);
  endfunction

  function automatic longint slope(longint a, longint b, longint x);
    return clamp32(qmul(x, b) - a);
  endfunction

  task automatic integrate(longint x);
    longint h, hh, h6, y1, y2, xm, xf;
    longint a1, b1, a2, b2, a3, b3, a4, b4, p1, p2;
    h = longint'(h_reg); hh = h >>> 1; h6 = h / 6;
    y1 = y1_st; y2 = y2_st;
    xm = clamp32(x + hh); xf = clamp32(x + h);
    a1 = y2; b1 = slope(y1, y2, x);
    case (meth_reg)
      METH_EULER: begin
        y1 = clamp32(y1 + qmul(a1, h));
        y2 = clamp32(y2 + qmul(b1, h));
      end
      METH_MID: begin
        p1 = clamp32(y1 + qmul(a1, hh)); p2 = clamp32(y2 + qmul(b1, hh));
        a2 = p2; b2 = slope(p1, p2, xm);
        y1 = clamp32(y1 + qmul(a2, h));
        y2 = clamp32(y2 + qmul(b2, h));
      end
      METH_HEUN: begin
        p1 = clamp32(y1 + qmul(a1, h)); p2 = clamp32(y2 + qmul(b1, h));
        a2 = p2; b2 = slope(p1, p2, xf);
        y1 = clamp32(y1 + qmul(a1 + a2, hh));
        y2 = clamp32(y2 + qmul(b1 + b2, hh));
      end
      default: begin
        p1 = clamp32(y1 + qmul(a1, hh)); p2 = clamp32(y2 + qmul(b1, hh));
        a2 = p2; b2 = slope(p1, p2, xm);
        p1 = clamp32(y1 + qmul(a2, hh)); p2 = clamp32(y2 + qmul(b2, hh));
        a3 = p2; b3 = slope(p1, p2, xm);
        p1 = clamp32(y1 + qmul(a3, h)); p2 = clamp32(y2 + qmul(b3, h));
        a4 = p2; b4 = slope(p1, p2, xf);
        y1 = clamp32(y1 + qmul(a1 + 2 * a2 + 2 * a3 + a4, h6));
        y2 = clamp32(y2 + qmul(b1 + 2 * b2 + 2 * b3 + b4, h6));
      end
    endcase
    y1_st = y1; y2_st = y2;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want, got;
    if (!rst_ni) begin
      h_reg = STEP_RST; meth_reg = METH_RK4;
      y1_st = 64'sd2 <<< FRAC_BITS_DEF; y2_st = 64'sd1 <<< FRAC_BITS_DEF;
      expected_q.delete();
      fail_count_o = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_addr_i == REG_STEP_SIZE) h_reg = cfg_wdata_i[STEP_W-1:0];
        else if (cfg_addr_i == REG_METHOD) meth_reg = method_e'(cfg_wdata_i[1:0]);
      end
      if (out_valid_i && out_ready_i) begin
        got = out_item_i;
        if (expected_q.size() == 0) begin
          $error("result with no expectation: %h", got);
          fail_count_o++;
        end else begin
          want = expected_q.pop_front();
          if (got.first_out !== want.first_out) begin
            $error("first_out: expected %0d actual %0d", want.first_out, got.first_out);
            fail_count_o++;
          end
          if (got.second_out !== want.second_out) begin
            $error("second_out: expected %0d actual %0d", want.second_out,
                   got.second_out);
            fail_count_o++;
          end
          if (got.saturated !== want.saturated) begin
            $error("saturated: expected %0b actual %0b", want.saturated, got.saturated);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        clamped = 0;
        if (in_item_i.operation == OP_LOAD) begin
          y1_st = longint'(in_item_i.load_first);
          y2_st = longint'(in_item_i.load_second);
        end else begin
          integrate(longint'(in_item_i.abscissa));
        end
        want.first_out = y1_st[31:0];
        want.second_out = y2_st[31:0];
        want.saturated = clamped;
        expected_q.push_back(want);
      end
    end
    pending_o = expected_q.size();
  end

endmodule

// File: verif/tb_ode_system_step_solver_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ode_system_step_solver_core
// Drives step and load items through the solver under several step sizes
// and all four methods, with random gaps and stalls; a checker beside the
// block predicts each result and counts mismatches.
// ----------------------------------------------------------------------------
module tb_ode_system_step_solver_core;
  import odess_pkg::*;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [CFG_AW-1:0] cfg_addr_i = '0;
  logic [CFG_DW-1:0] cfg_wdata_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  in_item_t          in_item_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  out_item_t         out_item_o;
  int                fail_count, pending;
  bit                hold_off_sink = 1'b0;  // long receiver stall on request

  always #6 clk_i = ~clk_i;

  ode_system_step_solver_core dut (.*);

  ode_step_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_addr_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_i(in_ready_o), .in_item_i,
    .out_valid_i(out_valid_o), .out_ready_i, .out_item_i(out_item_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Pick a gap length: mostly none or short, now and then long.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Receiver: random stalls, plus a long hold-off while hold_off_sink is up.
  always @(posedge clk_i) begin
    int stall;
    if (rst_ni) begin
      if (hold_off_sink) begin
        out_ready_i <= 1'b0;
      end else begin
        stall = gap_len();
        out_ready_i <= (stall == 0);
      end
    end
  end

  // Drop valid after the last transfer before the sender waits.
  task automatic idle_input();
    in_valid_i <= 1'b0;
  endtask

  // Drop valid for a random gap, present one item and hold it until the transfer.
  task automatic send_item(logic op, logic [31:0] x, logic [31:0] f, logic [31:0] s);
    int g;
    in_item_t it;
    g = gap_len();
    if (g != 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    it.operation = op; it.abscissa = x; it.load_first = f; it.load_second = s;
    in_valid_i <= 1'b1;
    in_item_i <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic send_step(logic [31:0] x);
    send_item(OP_STEP, x, $urandom, $urandom);
  endtask

  task automatic send_load(logic [31:0] f, logic [31:0] s);
    send_item(OP_LOAD, $urandom, f, s);
  endtask

  // Drain all expected results, let the block settle, then write a register.
  task automatic write_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] val);
    idle_input();
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Random values biased toward small magnitudes so trajectories stay in range.
  function automatic logic [31:0] rand_val();
    case ($urandom_range(0, 5))
      0:       return $urandom;
      1:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
    endcase
  endfunction

  function automatic logic [CFG_DW-1:0] rand_step();
    case ($urandom_range(0, 7))
      0:       return 17'd65536;
      1:       return 17'd1;
      2:       return 17'h1FFFF;
      3:       return 17'd0;
      default: return CFG_DW'($urandom_range(1, 65536));
    endcase
  endfunction

  initial begin
    int phase, n;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset state under RK4, extremes of every field, loads.
    send_step(32'd0);
    send_step(32'h7FFF_FFFF);
    send_step(32'h8000_0000);
    send_load(32'h7FFF_FFFF, 32'h8000_0000);
    send_step(32'h7FFF_FFFF);
    send_load(32'h8000_0000, 32'h7FFF_FFFF);
    send_step(32'h8000_0000);
    send_load(32'hFFFF_FFFF, 32'h0000_0000);
    send_step(32'hFFFF_FFFF);
    for (int m = 0; m < 4; m++) begin
      write_reg(REG_METHOD, CFG_DW'(m));
      send_load(32'h0002_0000, 32'h0001_0000);
      send_step(32'h0001_0000);
      send_load(32'h7FFF_0000, 32'h7FFF_0000);
      send_step(32'h0100_0000);
    end
    // Zero step keeps the pair, and a step above one is used as given.
    write_reg(REG_STEP_SIZE, 17'd0);
    send_step(32'h0003_0000);
    write_reg(REG_STEP_SIZE, 17'h1FFFF);
    send_step(32'h0000_8000);

    // Random phases across settings; reload the pair often to stay bounded.
    for (phase = 0; phase < 26; phase++) begin
      write_reg(REG_STEP_SIZE, (phase == 0) ? 17'd65536 : rand_step());
      write_reg(REG_METHOD, CFG_DW'(phase % 4));
      n = 0;
      while (n < 50) begin
        if ($urandom_range(0, 9) == 0) send_load(rand_val(), rand_val());
        else send_step(rand_val());
        n++;
        if (phase == 5 && n == 10) begin
          hold_off_sink = 1'b1;
          fork
            begin
              repeat (300) @(posedge clk_i);
              hold_off_sink = 1'b0;
            end
          join_none
        end
        if (phase == 8 && n == 25) begin
          idle_input();
          @(posedge clk_i);
          while (pending != 0) @(posedge clk_i);
        end
      end
    end

    idle_input();
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
